// File: src/kpdc_pkg.sv
// Package: shared constants, register indices and structs for the key press classifier.
`timescale 1ns / 1ps

package kpdc_pkg;

    // Width of the tick clock and of all stored times.
    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 8;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CFG_BITS-1:0]  cfg_word_t;
    typedef logic [IDX_BITS-1:0]  cfg_idx_t;

    // Configuration register indices.
    localparam cfg_idx_t REG_SHORT_MIN = cfg_idx_t'(0);
    localparam cfg_idx_t REG_LONG_MIN  = cfg_idx_t'(1);
    localparam cfg_idx_t REG_WINDOW    = cfg_idx_t'(2);
    localparam cfg_idx_t REG_QUIET_GAP = cfg_idx_t'(3);

    // Reset values of the configuration registers.
    localparam cfg_word_t SHORT_MIN_RST = cfg_word_t'(1000);
    localparam cfg_word_t LONG_MIN_RST  = cfg_word_t'(5000);
    localparam cfg_word_t WINDOW_RST    = cfg_word_t'(3500);
    localparam cfg_word_t QUIET_GAP_RST = cfg_word_t'(200);

    typedef struct packed {
        cfg_word_t short_min_ticks;
        cfg_word_t long_min_ticks;
        cfg_word_t window_ticks;
        cfg_word_t quiet_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic short_match;
        logic long_match;
        logic deep_sleep_mode;
        logic resume_request;
    } result_t;

endpackage

// File: src/key_press_duration_classifier.sv
// Top level of the key press duration classifier: handshakes and pipeline registers.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_key_event, s_suspended (one tick per word)
// m_        out        m_valid / m_ready    m_short_match, m_long_match,
//                                           m_deep_sleep_mode, m_resume_request
// cfg_      in         cfg_valid / cfg_ready cfg_index (8 bits), cfg_data (16 bits)
//
// A word is accepted into the input register and then passes through the tracker into
// the result register once that register is free or being emptied; the result is offered
// from there. A new word is taken in every cycle while the result side drains, so the
// sustained rate is one word per cycle; the figure is set by the single tracker pass on
// the registered tick time. A stall on m_ready holds the result register and then the
// input register, and s_ready falls only when both are full and m_ready is low. Reset is
// synchronous and active low; it empties both registers, clears the tick clock and press
// state, and loads the configuration defaults. cfg_ready is always high.

module key_press_duration_classifier
    import kpdc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,

    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_key_event,
    input  logic      s_suspended,

    output logic      m_valid,
    input  logic      m_ready,
    output logic      m_short_match,
    output logic      m_long_match,
    output logic      m_deep_sleep_mode,
    output logic      m_resume_request,

    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_idx_t  cfg_index,
    input  cfg_word_t cfg_data
);

    cfg_t    cfg;
    result_t res;
    result_t res_reg;

    logic in_valid_reg;
    logic key_event_reg;
    logic suspended_reg;
    logic out_valid_reg;
    logic advance;

    // The tracker fires when the input register holds a word and the result
    // register is free or being emptied in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    kpdc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kpdc_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .key_event (key_event_reg),
        .suspended (suspended_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // Input register: control bit cleared by reset, payload loaded on acceptance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_event_reg <= s_key_event;
            suspended_reg <= s_suspended;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_short_match     = res_reg.short_match;
    assign m_long_match      = res_reg.long_match;
    assign m_deep_sleep_mode = res_reg.deep_sleep_mode;
    assign m_resume_request  = res_reg.resume_request;

endmodule

// File: src/kpdc_cfg_regs.sv
// Configuration register bank for the key press classifier.
`timescale 1ns / 1ps

module kpdc_cfg_regs
    import kpdc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_idx_t  cfg_index,
    input  cfg_word_t cfg_data,
    output cfg_t      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SHORT_MIN: cfg_next.short_min_ticks = cfg_data;
                REG_LONG_MIN:  cfg_next.long_min_ticks  = cfg_data;
                REG_WINDOW:    cfg_next.window_ticks    = cfg_data;
                REG_QUIET_GAP: cfg_next.quiet_gap_ticks = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_min_ticks <= SHORT_MIN_RST;
            cfg_reg.long_min_ticks  <= LONG_MIN_RST;
            cfg_reg.window_ticks    <= WINDOW_RST;
            cfg_reg.quiet_gap_ticks <= QUIET_GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/kpdc_tracker.sv
// Press tracking state and duration classification for one tick.
`timescale 1ns / 1ps

module kpdc_tracker
    import kpdc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  logic    key_event,
    input  logic    suspended,
    input  cfg_t    cfg,
    output result_t res
);

    time_t tick_clock_reg;
    time_t press_start_reg;
    time_t last_event_reg;
    logic  press_active_reg;
    logic  sleep_flag_reg;

    time_t tick_clock_next;
    time_t press_start_next;
    time_t last_event_next;
    logic  press_active_next;
    logic  sleep_flag_next;

    time_t            gap;
    time_t            dur;
    logic [CFG_BITS:0] short_hi;
    logic [CFG_BITS:0] long_hi;
    logic             press_end;
    logic             in_short;
    logic             in_long;

    // press_end requires a tick with no key event, so a press can only end on a quiet tick
    // and then the stored times are the ones in use.
    assign gap      = tick_clock_reg - last_event_reg;
    assign dur      = last_event_reg - press_start_reg;
    assign short_hi = {1'b0, cfg.short_min_ticks} + {1'b0, cfg.window_ticks};
    assign long_hi  = {1'b0, cfg.long_min_ticks} + {1'b0, cfg.window_ticks};

    assign press_end = !key_event && press_active_reg
                       && (gap > time_t'(cfg.quiet_gap_ticks));
    assign in_short  = (dur > time_t'(cfg.short_min_ticks)) && (dur < time_t'(short_hi));
    assign in_long   = (dur > time_t'(cfg.long_min_ticks)) && (dur < time_t'(long_hi));

    always_comb begin
        tick_clock_next   = tick_clock_reg + time_t'(1);
        press_start_next  = press_start_reg;
        last_event_next   = last_event_reg;
        press_active_next = press_active_reg;
        sleep_flag_next   = sleep_flag_reg;

        res.short_match    = 1'b0;
        res.long_match     = 1'b0;
        res.resume_request = 1'b0;

        if (key_event) begin
            if (!press_active_reg) begin
                press_active_next = 1'b1;
                press_start_next  = tick_clock_reg;
            end
            last_event_next = tick_clock_reg;
        end

        if (press_end) begin
            // When both windows match, both match flags are set and the long rule wins the sleep flag.
            if (in_short) begin
                res.short_match    = 1'b1;
                res.resume_request = suspended;
                sleep_flag_next    = 1'b0;
            end
            if (in_long) begin
                res.long_match  = 1'b1;
                sleep_flag_next = 1'b1;
            end
            press_active_next = 1'b0;
            press_start_next  = '0;
            last_event_next   = '0;
        end

        res.deep_sleep_mode = sleep_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_clock_reg   <= '0;
            press_start_reg  <= '0;
            last_event_reg   <= '0;
            press_active_reg <= 1'b0;
            sleep_flag_reg   <= 1'b0;
        end else if (step) begin
            tick_clock_reg   <= tick_clock_next;
            press_start_reg  <= press_start_next;
            last_event_reg   <= last_event_next;
            press_active_reg <= press_active_next;
            sleep_flag_reg   <= sleep_flag_next;
        end
    end

`ifndef SYNTH
    a_event_starts_press: assert property (@(posedge aclk) disable iff (!aresetn)
        step && key_event |=> press_active_reg)
        else $error("key event did not leave a press in progress");

    a_end_clears_press: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (res.short_match || res.long_match) |=> !press_active_reg)
        else $error("press still active after it was classified");

    a_resume_needs_short: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.resume_request |-> res.short_match && suspended)
        else $error("resume request without a short press while suspended");

    a_long_sets_sleep: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.long_match |=> sleep_flag_reg)
        else $error("long press did not set the deep sleep flag");

    a_tick_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> tick_clock_reg == $past(tick_clock_reg) + time_t'(1))
        else $error("tick clock did not advance by one");
`endif

endmodule
